### rtl/lcdn_pkg.sv
// Shared types, codes and script tables for the 4-bit character LCD controller.
package lcdn_pkg;

    // Request opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_INIT   = 3'd1;
    localparam logic [2:0] OP_CMD    = 3'd2;
    localparam logic [2:0] OP_DATA   = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;
    localparam logic [2:0] OP_FILL   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    // Configuration register indexes
    localparam logic [7:0] REG_SHORT_DELAY   = 8'd0;
    localparam logic [7:0] REG_POWERUP_DELAY = 8'd1;
    localparam logic [7:0] REG_RESTART_DELAY = 8'd2;
    localparam logic [7:0] REG_ROW_ZERO_BASE = 8'd3;
    localparam logic [7:0] REG_ROW_ONE_BASE  = 8'd4;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;

    // Script steps with a special meaning
    localparam logic [4:0] STEP_IDLE      = 5'd0;
    localparam logic [4:0] STEP_INIT      = 5'd1;
    localparam logic [4:0] STEP_LAST_INIT = 5'd16;
    localparam logic [4:0] STEP_HELD      = 5'd17;
    localparam logic [4:0] STEP_FILL      = 5'd18;

    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] SET_DDRAM_CMD = 8'h80;

    typedef enum logic [2:0] {
        K_IDLE,
        K_WAIT_SHORT,
        K_WAIT_POWER,
        K_WAIT_RESTART,
        K_NIB,
        K_BYTE,
        K_HELD,
        K_FILL
    } step_kind_t;

    typedef struct packed {
        logic [9:0] short_delay;
        logic [9:0] powerup_delay;
        logic [9:0] restart_delay;
        logic [6:0] row_zero_base;
        logic [6:0] row_one_base;
    } cfg_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] col;
    } item_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_enable;
        logic [3:0] pin_data;
        logic       busy_res;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [4:0] step;
        logic [9:0] wait_cnt;
        logic [7:0] byte_hold;
        logic [1:0] phase;
        logic       sel;
        logic       strobe;
        logic [3:0] nib;
        logic [6:0] fill_left;
    } seq_state_t;

    function automatic step_kind_t step_kind(logic [4:0] step);
        step_kind_t k;
        unique case (step)
            5'd1:  k = K_WAIT_POWER;
            5'd2:  k = K_NIB;
            5'd3:  k = K_WAIT_RESTART;
            5'd4:  k = K_NIB;
            5'd5:  k = K_WAIT_SHORT;
            5'd6:  k = K_NIB;
            5'd7:  k = K_WAIT_SHORT;
            5'd8:  k = K_NIB;
            5'd9:  k = K_WAIT_SHORT;
            5'd10: k = K_BYTE;
            5'd11: k = K_BYTE;
            5'd12: k = K_WAIT_SHORT;
            5'd13: k = K_BYTE;
            5'd14: k = K_BYTE;
            5'd15: k = K_BYTE;
            5'd16: k = K_WAIT_SHORT;
            5'd17: k = K_HELD;
            5'd18: k = K_FILL;
            default: k = K_IDLE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] step_val(logic [4:0] step);
        logic [7:0] v;
        unique case (step)
            5'd2:  v = 8'h03;
            5'd4:  v = 8'h03;
            5'd6:  v = 8'h03;
            5'd8:  v = 8'h02;
            5'd10: v = 8'h28;
            5'd11: v = 8'h08;
            5'd13: v = 8'h01;
            5'd14: v = 8'h06;
            5'd15: v = 8'h0C;
            5'd18: v = SPACE_CHAR;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [9:0] at_least_one(logic [9:0] d);
        return (d == 10'd0) ? 10'd1 : d;
    endfunction

endpackage

### rtl/lcdn_ifs.sv
// Handshake channel interfaces: request, result and configuration write.
interface lcdn_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] col;

    modport source (output valid, output opcode, output value, output row, output col,
                    input ready);
    modport sink   (input valid, input opcode, input value, input row, input col,
                    output ready);
endinterface

interface lcdn_rsp_if;
    logic       valid;
    logic       ready;
    logic       pin_rs;
    logic       pin_enable;
    logic [3:0] pin_data;
    logic       busy_res;
    logic [1:0] status;

    modport source (output valid, output pin_rs, output pin_enable, output pin_data,
                    output busy_res, output status, input ready);
    modport sink   (input valid, input pin_rs, input pin_enable, input pin_data,
                    input busy_res, input status, output ready);
endinterface

interface lcdn_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/lcdn_cfg_regs.sv
// Configuration register file for delays and row base addresses.
module lcdn_cfg_regs
    import lcdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_index,
    input  logic [9:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SHORT_DELAY:   cfg_next.short_delay   = wr_data;
                REG_POWERUP_DELAY: cfg_next.powerup_delay = wr_data;
                REG_RESTART_DELAY: cfg_next.restart_delay = wr_data;
                REG_ROW_ZERO_BASE: cfg_next.row_zero_base = wr_data[6:0];
                REG_ROW_ONE_BASE:  cfg_next.row_one_base  = wr_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay   <= 10'd2;
            cfg_reg.powerup_delay <= 10'd20;
            cfg_reg.restart_delay <= 10'd5;
            cfg_reg.row_zero_base <= 7'd0;
            cfg_reg.row_one_base  <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lcdn_in_stage.sv
// Input register stage: holds one request until the sequencer takes it.
module lcdn_in_stage
    import lcdn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/lcdn_seq.sv
// Script sequencer: applies one item per cycle unless rsp backpressure stalls it, and registers the pin result.
module lcdn_seq
    import lcdn_pkg::*;
#(
    parameter int COLUMNS   = 16,
    parameter int ROWS_USED = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  take,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  res
);

    localparam logic [6:0] FILL_COUNT = 7'(COLUMNS);
    localparam logic [6:0] COL_LIMIT  = 7'(COLUMNS);
    localparam logic [2:0] ROW_LIMIT  = 3'(ROWS_USED);

    seq_state_t st_reg;
    seq_state_t st_next;
    res_t       res_reg;
    res_t       res_next;
    logic       out_valid_reg;

    function automatic seq_state_t enter_step(seq_state_t s, logic [4:0] step, cfg_t c);
        seq_state_t r;
        logic [7:0] v;
        r       = s;
        v       = step_val(step);
        r.step  = step;
        r.phase = 2'd0;
        unique case (step_kind(step))
            K_WAIT_POWER:
            begin
                r.sel      = 1'b0;
                r.strobe   = 1'b0;
                r.nib      = 4'd0;
                r.wait_cnt = at_least_one(c.powerup_delay);
            end
            K_WAIT_SHORT:   r.wait_cnt = at_least_one(c.short_delay);
            K_WAIT_RESTART: r.wait_cnt = at_least_one(c.restart_delay);
            K_NIB:
            begin
                r.sel      = 1'b0;
                r.nib      = v[3:0];
                r.strobe   = 1'b1;
                r.wait_cnt = at_least_one(c.short_delay);
            end
            K_BYTE, K_FILL:
            begin
                r.sel       = (step_kind(step) == K_FILL);
                r.byte_hold = v;
                r.nib       = v[7:4];
                r.strobe    = 1'b1;
                r.wait_cnt  = at_least_one(c.short_delay);
            end
            K_HELD:
            begin
                r.nib      = s.byte_hold[7:4];
                r.strobe   = 1'b1;
                r.wait_cnt = at_least_one(c.short_delay);
            end
            K_IDLE:
            begin
                r.step     = STEP_IDLE;
                r.wait_cnt = 10'd0;
            end
        endcase
        return r;
    endfunction

    function automatic seq_state_t finish_step(seq_state_t s, cfg_t c);
        seq_state_t r;
        r = s;
        if (s.step == STEP_FILL)
        begin
            if (s.fill_left != 7'd0)
            begin
                r.fill_left = s.fill_left - 7'd1;
            end
            r = enter_step(r, (r.fill_left != 7'd0) ? STEP_FILL : STEP_IDLE, c);
        end
        else if (s.step == STEP_LAST_INIT || s.step >= STEP_HELD)
        begin
            r = enter_step(r, STEP_IDLE, c);
        end
        else
        begin
            r = enter_step(r, s.step + 5'd1, c);
        end
        return r;
    endfunction

    function automatic seq_state_t phase_done(seq_state_t s, cfg_t c);
        seq_state_t r;
        step_kind_t k;
        r = s;
        k = step_kind(s.step);
        if (k == K_WAIT_SHORT || k == K_WAIT_POWER || k == K_WAIT_RESTART)
        begin
            r = finish_step(s, c);
        end
        else if (s.phase == 2'd0 || s.phase == 2'd2)
        begin
            r.strobe   = 1'b0;
            r.phase    = s.phase + 2'd1;
            r.wait_cnt = at_least_one(c.short_delay);
        end
        else if (s.phase == 2'd1 && k != K_NIB)
        begin
            // second nibble of a byte
            r.phase    = 2'd2;
            r.nib      = s.byte_hold[3:0];
            r.strobe   = 1'b1;
            r.wait_cnt = at_least_one(c.short_delay);
        end
        else
        begin
            r = finish_step(s, c);
        end
        return r;
    endfunction

    assign take = !out_valid_reg || out_ready;

    always_comb
    begin
        logic       busy;
        logic [6:0] base;
        logic [7:0] addr;
        seq_state_t s;
        logic [1:0] status;

        s      = st_reg;
        status = ST_OK;
        busy   = (st_reg.step != STEP_IDLE);
        base   = (item.row == 2'd0) ? cfg.row_zero_base : cfg.row_one_base;
        addr   = (8'(base) + 8'(item.col)) | SET_DDRAM_CMD;

        if (item.opcode == OP_TICK)
        begin
            if (busy)
            begin
                if (s.wait_cnt != 10'd0)
                begin
                    s.wait_cnt = s.wait_cnt - 10'd1;
                end
                if (s.wait_cnt == 10'd0)
                begin
                    s = phase_done(s, cfg);
                end
            end
        end
        else if (item.opcode <= OP_FILL && busy)
        begin
            status = ST_BUSY;
        end
        else if (item.opcode == OP_INIT)
        begin
            s = enter_step(s, STEP_INIT, cfg);
        end
        else if (item.opcode == OP_CMD || item.opcode == OP_DATA)
        begin
            s.byte_hold = item.value;
            s.sel       = (item.opcode == OP_DATA);
            s = enter_step(s, STEP_HELD, cfg);
        end
        else if (item.opcode == OP_CURSOR)
        begin
            if ({1'b0, item.row} >= ROW_LIMIT || {1'b0, item.col} >= COL_LIMIT)
            begin
                status = ST_RANGE;
            end
            else
            begin
                s.byte_hold = addr;
                s.sel       = 1'b0;
                s = enter_step(s, STEP_HELD, cfg);
            end
        end
        else if (item.opcode == OP_FILL)
        begin
            s.fill_left = FILL_COUNT;
            s = enter_step(s, (FILL_COUNT != 7'd0) ? STEP_FILL : STEP_IDLE, cfg);
        end

        st_next             = s;
        res_next.pin_rs     = s.sel;
        res_next.pin_enable = s.strobe;
        res_next.pin_data   = s.nib;
        res_next.busy_res   = (s.step != STEP_IDLE);
        res_next.status     = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= item_valid;
            end
            if (take && item_valid)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/char_lcd_nibble_interface.sv
// Top level of the 4-bit character LCD controller.
// Each transfer on req is a millisecond tick or a request (init, command byte, data
// character, set cursor, fill a row with spaces); each one yields exactly one transfer on
// rsp carrying the RS, E and D4-D7 levels after that item, a busy flag and a status. One
// item is taken per clock. A request is taken into the input register, and the sequencer's
// update then loads the result register and raises rsp.valid. Backpressure on rsp stalls
// req. Requests made while a sequence runs are answered with the busy status and change
// nothing. Configuration writes on cfg are taken at any time and should be made while no
// items are in flight.
module char_lcd_nibble_interface
    import lcdn_pkg::*;
#(
    parameter int COLUMNS   = 16,
    parameter int ROWS_USED = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    lcdn_req_if.sink   req,
    lcdn_rsp_if.source rsp,
    lcdn_cfg_if.sink   cfg
);

    cfg_t  cfg_vals;
    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  take;
    res_t  res;

    assign cfg.ready = 1'b1;

    lcdn_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_vals)
    );

    assign in_item.opcode = req.opcode;
    assign in_item.value  = req.value;
    assign in_item.row    = req.row;
    assign in_item.col    = req.col;

    lcdn_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    lcdn_seq #(
        .COLUMNS   (COLUMNS),
        .ROWS_USED (ROWS_USED)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_vals),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .res        (res)
    );

    assign rsp.pin_rs     = res.pin_rs;
    assign rsp.pin_enable = res.pin_enable;
    assign rsp.pin_data   = res.pin_data;
    assign rsp.busy_res   = res.busy_res;
    assign rsp.status     = res.status;

endmodule

### tb/char_lcd_nibble_interface_tb.sv
// Self-checking testbench for the 4-bit character LCD controller.
`timescale 1ns / 1ps

module char_lcd_nibble_interface_tb;
    import lcdn_pkg::*;

    localparam int COLUMNS   = 16;
    localparam int ROWS_USED = 2;

    // opcodes the block leaves alone
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Tracks the LCD pin levels the controller should show after each request
    class lcd_pin_scoreboard;
        logic [9:0] short_dly;
        logic [9:0] power_dly;
        logic [9:0] restart_dly;
        logic [6:0] base0;
        logic [6:0] base1;

        logic [4:0] step;
        logic [9:0] wait_cnt;
        logic [7:0] byte_hold;
        logic [1:0] phase;
        logic       sel;
        logic       strobe;
        logic [3:0] nib;
        logic [6:0] fill_left;

        step_kind_t script_kind[19];
        logic [7:0] script_byte[19];
        res_t       pins_due[$];
        int         errors;

        function new();
            script_kind = '{K_IDLE, K_WAIT_POWER, K_NIB, K_WAIT_RESTART, K_NIB, K_WAIT_SHORT,
                            K_NIB, K_WAIT_SHORT, K_NIB, K_WAIT_SHORT, K_BYTE, K_BYTE,
                            K_WAIT_SHORT, K_BYTE, K_BYTE, K_BYTE, K_WAIT_SHORT, K_HELD, K_FILL};
            script_byte = '{8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h00, 8'h03, 8'h00, 8'h02,
                            8'h00, 8'h28, 8'h08, 8'h00, 8'h01, 8'h06, 8'h0C, 8'h00, 8'h00,
                            SPACE_CHAR};
            short_dly   = 10'd2;
            power_dly   = 10'd20;
            restart_dly = 10'd5;
            base0       = 7'd0;
            base1       = 7'd64;
            step        = STEP_IDLE;
            wait_cnt    = '0;
            byte_hold   = '0;
            phase       = '0;
            sel         = 1'b0;
            strobe      = 1'b0;
            nib         = '0;
            fill_left   = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [9:0] data);
            case (idx)
                REG_SHORT_DELAY:   short_dly = data;
                REG_POWERUP_DELAY: power_dly = data;
                REG_RESTART_DELAY: restart_dly = data;
                REG_ROW_ZERO_BASE: base0 = data[6:0];
                REG_ROW_ONE_BASE:  base1 = data[6:0];
                default: ;
            endcase
        endfunction

        function bit running();
            return step != STEP_IDLE;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction

        // a zero delay register behaves like one tick
        function logic [9:0] ticks_of(logic [9:0] d);
            return (d == 10'd0) ? 10'd1 : d;
        endfunction

        function step_kind_t kind_of(logic [4:0] s);
            return (s <= STEP_FILL) ? script_kind[s] : K_IDLE;
        endfunction

        function void strobe_nibble(logic [3:0] n);
            nib      = n;
            strobe   = 1'b1;
            wait_cnt = ticks_of(short_dly);
        endfunction

        function void enter_step(logic [4:0] s);
            step  = s;
            phase = 2'd0;
            case (kind_of(s))
                K_WAIT_POWER:
                begin
                    sel      = 1'b0;
                    strobe   = 1'b0;
                    nib      = 4'd0;
                    wait_cnt = ticks_of(power_dly);
                end
                K_WAIT_SHORT:   wait_cnt = ticks_of(short_dly);
                K_WAIT_RESTART: wait_cnt = ticks_of(restart_dly);
                K_NIB:
                begin
                    sel = 1'b0;
                    strobe_nibble(script_byte[s][3:0]);
                end
                K_BYTE:
                begin
                    sel       = 1'b0;
                    byte_hold = script_byte[s];
                    strobe_nibble(byte_hold[7:4]);
                end
                K_HELD: strobe_nibble(byte_hold[7:4]);
                K_FILL:
                begin
                    sel       = 1'b1;
                    byte_hold = script_byte[s];
                    strobe_nibble(byte_hold[7:4]);
                end
                default:
                begin
                    step     = STEP_IDLE;
                    wait_cnt = '0;
                end
            endcase
        endfunction

        function void finish_step();
            if (step == STEP_FILL)
            begin
                if (fill_left != 0)
                    fill_left--;
                enter_step((fill_left != 0) ? STEP_FILL : STEP_IDLE);
            end
            else if (step == STEP_LAST_INIT || step >= STEP_HELD)
                enter_step(STEP_IDLE);
            else
                enter_step(step + 5'd1);
        endfunction

        // phases 0 and 2: E high; 1 and 3: E low
        function void phase_done();
            step_kind_t k;
            k = kind_of(step);
            if (k == K_WAIT_SHORT || k == K_WAIT_POWER || k == K_WAIT_RESTART)
                finish_step();
            else if (phase == 2'd0 || phase == 2'd2)
            begin
                strobe   = 1'b0;
                phase    = phase + 2'd1;
                wait_cnt = ticks_of(short_dly);
            end
            else if (phase == 2'd1 && k != K_NIB)
            begin
                phase = 2'd2;
                strobe_nibble(byte_hold[3:0]);
            end
            else
                finish_step();
        endfunction

        function void note_request(item_t it);
            res_t       want;
            logic [1:0] status;
            logic [7:0] addr;
            status = ST_OK;
            if (it.opcode == OP_TICK)
            begin
                if (running())
                begin
                    if (wait_cnt > 0)
                        wait_cnt--;
                    if (wait_cnt == 0)
                        phase_done();
                end
            end
            else if (it.opcode <= OP_FILL && running())
                status = ST_BUSY;
            else
            begin
                case (it.opcode)
                    OP_INIT: enter_step(STEP_INIT);
                    OP_CMD, OP_DATA:
                    begin
                        byte_hold = it.value;
                        sel       = (it.opcode == OP_DATA);
                        enter_step(STEP_HELD);
                    end
                    OP_CURSOR:
                    begin
                        if (it.row >= ROWS_USED || it.col >= COLUMNS)
                            status = ST_RANGE;
                        else
                        begin
                            addr = {1'b0, (it.row == 2'd0) ? base0 : base1} + {2'b0, it.col};
                            byte_hold = addr | SET_DDRAM_CMD;
                            sel       = 1'b0;
                            enter_step(STEP_HELD);
                        end
                    end
                    OP_FILL:
                    begin
                        fill_left = 7'(COLUMNS);
                        enter_step((fill_left != 0) ? STEP_FILL : STEP_IDLE);
                    end
                    default: ;
                endcase
            end
            want.pin_rs     = sel;
            want.pin_enable = strobe;
            want.pin_data   = nib;
            want.busy_res   = running();
            want.status     = status;
            pins_due.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pins(res_t got);
            res_t want;
            if (pins_due.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = pins_due.pop_front();
            if (got.pin_rs !== want.pin_rs)
                report($sformatf("pin_rs %b, expected %b", got.pin_rs, want.pin_rs));
            if (got.pin_enable !== want.pin_enable)
                report($sformatf("pin_enable %b, expected %b", got.pin_enable, want.pin_enable));
            if (got.pin_data !== want.pin_data)
                report($sformatf("pin_data %h, expected %h", got.pin_data, want.pin_data));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct;
    int snk_idle_pct;
    int sent;
    bit hold_rsp;

    lcd_pin_scoreboard board = new();

    lcdn_req_if req_ch();
    lcdn_rsp_if rsp_ch();
    lcdn_cfg_if cfg_ch();

    char_lcd_nibble_interface #(
        .COLUMNS   (COLUMNS),
        .ROWS_USED (ROWS_USED)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    task automatic send_op(input logic [2:0] op, input logic [7:0] val,
                           input logic [1:0] r, input logic [5:0] c);
        item_t it;
        it.opcode = op;
        it.value  = val;
        it.row    = r;
        it.col    = c;
        // each cycle the sender stays quiet with the idle percentage
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.opcode = op;
        req_ch.value  = val;
        req_ch.row    = r;
        req_ch.col    = c;
        req_ch.valid  = 1'b1;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        board.note_request(it);
        sent++;
        @(negedge clk);
    endtask

    // the other fields of a tick are don't-care, so they carry noise
    task automatic send_tick();
        send_op(OP_TICK, 8'($urandom), 2'($urandom), 6'($urandom));
    endtask

    task automatic ticks_until_quiet(input int noise_pct);
        while (board.running())
        begin
            if ($urandom_range(99) < noise_pct)
                send_op(3'($urandom_range(OP_INIT, OP_SPARE_HI)), 8'($urandom),
                        2'($urandom), 6'($urandom));
            else
                send_tick();
        end
    endtask

    task automatic random_request();
        int         pick;
        int         style;
        logic [2:0] op;
        logic [1:0] r;
        logic [5:0] c;
        pick = $urandom_range(99);
        if (pick < 6)
            op = OP_INIT;
        else if (pick < 26)
            op = OP_CMD;
        else if (pick < 50)
            op = OP_DATA;
        else if (pick < 74)
            op = OP_CURSOR;
        else if (pick < 80)
            op = OP_FILL;
        else if (pick < 88)
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            op = OP_TICK;
        if ($urandom_range(3) != 0)
        begin
            r = 2'($urandom_range(ROWS_USED - 1));
            c = 6'($urandom_range(COLUMNS - 1));
        end
        else
        begin
            r = 2'($urandom);
            c = 6'($urandom);
        end
        send_op(op, 8'($urandom), r, c);
        // mostly let the sequence run out; sometimes cut it short so the next one is refused
        style = $urandom_range(9);
        if (style == 1)
            repeat ($urandom_range(1, 6)) send_tick();
        else if (style > 1)
            ticks_until_quiet(5);
    endtask

    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [9:0] data);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [9:0] short_d, input logic [9:0] power_d,
                                input logic [9:0] restart_d, input logic [9:0] b0,
                                input logic [9:0] b1);
        cfg_write(REG_SHORT_DELAY, short_d);
        cfg_write(REG_POWERUP_DELAY, power_d);
        cfg_write(REG_RESTART_DELAY, restart_d);
        cfg_write(REG_ROW_ZERO_BASE, b0);
        cfg_write(REG_ROW_ONE_BASE, b1);
        cfg_ch.valid = 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready = 1'b0;
                repeat (80) @(negedge clk);
                hold_rsp = 1'b0;
            end
            rsp_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_pins({rsp_ch.pin_rs, rsp_ch.pin_enable, rsp_ch.pin_data,
                              rsp_ch.busy_res, rsp_ch.status});
    end

    initial
    begin
        int o;
        rst_n         = 1'b0;
        hold_rsp      = 1'b0;
        sent          = 0;
        src_idle_pct  = 23;
        snk_idle_pct  = 63;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_TICK;
        req_ch.value  = '0;
        req_ch.row    = '0;
        req_ch.col    = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle ticks, ignored opcodes, full init, busy refusals, byte extremes
        send_op(OP_TICK, 8'hFF, 2'd3, 6'd63);
        send_op(OP_SPARE_LO, 8'hFF, 2'd3, 6'd63);
        send_op(OP_SPARE_HI, 8'h00, 2'd0, 6'd0);
        send_op(OP_CURSOR, 8'h00, 2'd0, 6'd0);
        ticks_until_quiet(0);
        send_op(OP_INIT, 8'h00, 2'd0, 6'd0);
        repeat (3) send_tick();
        for (o = OP_INIT; o <= OP_SPARE_HI; o++)
            send_op(3'(o), 8'hFF, 2'd3, 6'd63);
        ticks_until_quiet(0);
        send_op(OP_CMD, 8'h00, 2'd0, 6'd0);
        ticks_until_quiet(0);
        send_op(OP_CMD, 8'hFF, 2'd3, 6'd63);
        ticks_until_quiet(0);
        send_op(OP_DATA, 8'h00, 2'd0, 6'd0);
        ticks_until_quiet(0);
        send_op(OP_DATA, 8'hFF, 2'd3, 6'd63);
        ticks_until_quiet(0);
        send_op(OP_CURSOR, 8'h00, 2'd1, 6'd15);
        ticks_until_quiet(0);
        // out of range: row past the last, column past the last
        send_op(OP_CURSOR, 8'h00, 2'd0, 6'd16);
        send_op(OP_CURSOR, 8'h00, 2'd2, 6'd0);
        send_op(OP_CURSOR, 8'hFF, 2'd3, 6'd63);
        drain_results();

        program_regs(10'd1, 10'($urandom_range(1, 40)), 10'($urandom_range(1, 10)),
                     10'($urandom), 10'($urandom));
        // hold results back while a fill keeps the input busy
        send_op(OP_FILL, 8'h00, 2'd0, 6'd0);
        hold_rsp = 1'b1;
        ticks_until_quiet(0);
        while (sent < 290)
            random_request();
        ticks_until_quiet(0);
        drain_results();

        src_idle_pct = 63;
        snk_idle_pct = 23;
        program_regs(10'd0, 10'd0, 10'd0, 10'd127, 10'd0);
        while (sent < 355)
            random_request();
        ticks_until_quiet(0);
        drain_results();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_regs(10'($urandom_range(2, 3)), 10'($urandom_range(1, 60)),
                     10'($urandom_range(1, 20)), 10'($urandom), 10'($urandom));
        while (sent < 420)
            random_request();
        ticks_until_quiet(0);
        drain_results();

        // longest delays: only the opening of an init, with refusals while it waits
        program_regs(10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd127);
        send_op(OP_INIT, 8'h00, 2'd0, 6'd0);
        repeat (12) send_tick();
        send_op(OP_DATA, 8'hA5, 2'd0, 6'd0);
        send_op(OP_CURSOR, 8'h00, 2'd1, 6'd15);
        drain_results();

        repeat (8) @(negedge clk);
        if (board.errors == 0)
            $display("char_lcd_nibble_interface_tb: done, clean");
        else
            $display("char_lcd_nibble_interface_tb: done, errors");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("char_lcd_nibble_interface_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/lcdn_pkg.sv
rtl/lcdn_ifs.sv
rtl/lcdn_cfg_regs.sv
rtl/lcdn_in_stage.sv
rtl/lcdn_seq.sv
rtl/char_lcd_nibble_interface.sv
tb/char_lcd_nibble_interface_tb.sv
